### hdl/nearest_palette_color_mapper_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the nearest palette color mapper
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef NEAREST_PALETTE_COLOR_MAPPER_UNIT_ASSERT_SVH
`define NEAREST_PALETTE_COLOR_MAPPER_UNIT_ASSERT_SVH

// same-cycle implication
`define NPCM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define NPCM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/npcm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// npcm_pkg
// Shared types, constants and helpers of the nearest palette color mapper.
// ----------------------------------------------------------------------------
package npcm_pkg;

    localparam int MAX_ENTRIES = 8;
    localparam int CH_W        = 8;
    localparam int NUM_CH      = 3;
    localparam int COLOR_W     = 24;
    localparam int SQ_W        = 16;
    localparam int DIST_W      = 18;
    localparam int NUM_W       = 4;
    localparam int IDX_W       = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 56;
    localparam int PAIR_HI_LSB = 32;
    localparam int STAGES      = 5;

    localparam logic [NUM_W-1:0]  NUM_COLORS_RESET = 4'd1;
    localparam logic [DIST_W-1:0] MAX_DIST_RESET   = 18'd100000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NUM_COLORS = 3'd0,
        REG_MAX_DIST   = 3'd1,
        REG_PAIR_0     = 3'd2,
        REG_PAIR_1     = 3'd3,
        REG_PAIR_2     = 3'd4,
        REG_PAIR_3     = 3'd5
    } cfg_reg_t;

    typedef logic [COLOR_W-1:0] color_t;
    typedef logic [DIST_W-1:0]  dist_t;

    typedef struct packed {
        logic [NUM_W-1:0] num_colors;
        dist_t            max_distance;
    } cfg_ctl_t;

    // load enables, one per pipeline stage
    typedef struct packed {
        logic ld_s1;
        logic ld_s2;
        logic ld_s3;
        logic ld_s4;
        logic ld_s5;
    } pipe_ld_t;

    typedef struct packed {
        logic             hit;
        dist_t            sq_sum;
        logic [IDX_W-1:0] idx;
    } cand_t;

    // a is the lower entry: b wins only when strictly closer
    function automatic cand_t pick_closer(cand_t a, cand_t b);
        cand_t r;
        if (b.hit && (!a.hit || (b.sq_sum < a.sq_sum)))
        begin
            r = b;
        end
        else
        begin
            r = a;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### hdl/npcm_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// npcm_cfg
// Configuration registers: entry count, distance bound and palette colors.
// ----------------------------------------------------------------------------
module npcm_cfg #(
    parameter int PALETTE_SIZE = npcm_pkg::MAX_ENTRIES
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [npcm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [npcm_pkg::CFG_DATA_W-1:0]  cfg_data,
    output npcm_pkg::cfg_ctl_t                    cfg_ctl,
    output npcm_pkg::color_t                      palette [PALETTE_SIZE]
);
    import npcm_pkg::*;

    logic [NUM_W-1:0] num_colors_reg;
    dist_t            max_dist_reg;
    color_t           pal_reg [PALETTE_SIZE];
    logic             wr;

    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_colors_reg <= NUM_COLORS_RESET;
            max_dist_reg   <= MAX_DIST_RESET;
        end
        else if (wr)
        begin
            unique case (cfg_index)
                REG_NUM_COLORS: num_colors_reg <= cfg_data[NUM_W-1:0];
                REG_MAX_DIST:   max_dist_reg   <= cfg_data[DIST_W-1:0];
                default:        ;
            endcase
        end
    end

    // each pair register feeds two entries; entries past the palette are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int e = 0; e < PALETTE_SIZE; e++)
            begin
                pal_reg[e] <= '0;
            end
        end
        else if (wr)
        begin
            for (int e = 0; e < PALETTE_SIZE; e++)
            begin
                if (cfg_index == CFG_IDX_W'(int'(REG_PAIR_0) + (e >> 1)))
                begin
                    pal_reg[e] <= cfg_data[(e & 1) * PAIR_HI_LSB +: COLOR_W];
                end
            end
        end
    end

    assign cfg_ctl.num_colors   = num_colors_reg;
    assign cfg_ctl.max_distance = max_dist_reg;
    assign palette              = pal_reg;

endmodule
`default_nettype wire

### hdl/npcm_dist.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// npcm_dist
// Per-entry distance lanes: absolute difference, square, sum and bound check.
// ----------------------------------------------------------------------------
module npcm_dist #(
    parameter int PALETTE_SIZE = npcm_pkg::MAX_ENTRIES
) (
    input  wire logic                 clk,
    input  wire npcm_pkg::pipe_ld_t   ld,
    input  wire npcm_pkg::cfg_ctl_t   cfg_ctl,
    input  wire npcm_pkg::color_t     palette [PALETTE_SIZE],
    input  wire npcm_pkg::color_t     pixel_in,
    output npcm_pkg::color_t          pixel_s3,
    output logic [PALETTE_SIZE-1:0]   hit_s3,
    output npcm_pkg::dist_t           dist_s3 [PALETTE_SIZE]
);
    import npcm_pkg::*;

    color_t                         pix1_reg;
    color_t                         pix2_reg;
    color_t                         pix3_reg;
    logic [NUM_CH-1:0][CH_W-1:0]    diff1_reg [PALETTE_SIZE];
    logic [NUM_CH-1:0][SQ_W-1:0]    sq2_reg   [PALETTE_SIZE];
    logic [PALETTE_SIZE-1:0]        hit3_reg;
    dist_t                          dist3_reg [PALETTE_SIZE];

    logic [NUM_CH-1:0][CH_W-1:0]    diff1_next [PALETTE_SIZE];
    dist_t                          sum_next   [PALETTE_SIZE];

    always_comb
    begin
        for (int e = 0; e < PALETTE_SIZE; e++)
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                if (pixel_in[c*CH_W +: CH_W] >= palette[e][c*CH_W +: CH_W])
                begin
                    diff1_next[e][c] = pixel_in[c*CH_W +: CH_W] - palette[e][c*CH_W +: CH_W];
                end
                else
                begin
                    diff1_next[e][c] = palette[e][c*CH_W +: CH_W] - pixel_in[c*CH_W +: CH_W];
                end
            end
            sum_next[e] = DIST_W'(sq2_reg[e][0]) + DIST_W'(sq2_reg[e][1])
                        + DIST_W'(sq2_reg[e][2]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld.ld_s1)
        begin
            pix1_reg  <= pixel_in;
            diff1_reg <= diff1_next;
        end
        if (ld.ld_s2)
        begin
            pix2_reg <= pix1_reg;
            for (int e = 0; e < PALETTE_SIZE; e++)
            begin
                for (int c = 0; c < NUM_CH; c++)
                begin
                    sq2_reg[e][c] <= SQ_W'(diff1_reg[e][c] * diff1_reg[e][c]);
                end
            end
        end
        if (ld.ld_s3)
        begin
            pix3_reg  <= pix2_reg;
            dist3_reg <= sum_next;
            // an entry counts only when active and strictly inside the bound
            for (int e = 0; e < PALETTE_SIZE; e++)
            begin
                hit3_reg[e] <= (NUM_W'(e) < cfg_ctl.num_colors)
                            && (sum_next[e] < cfg_ctl.max_distance);
            end
        end
    end

    assign pixel_s3 = pix3_reg;
    assign hit_s3   = hit3_reg;
    assign dist_s3  = dist3_reg;

endmodule
`default_nettype wire

### hdl/npcm_select.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// npcm_select
// Two-stage reduction tree picking the closest matching entry, lowest on ties,
// and the output register.
// ----------------------------------------------------------------------------
module npcm_select #(
    parameter int PALETTE_SIZE = npcm_pkg::MAX_ENTRIES
) (
    input  wire logic                          clk,
    input  wire npcm_pkg::pipe_ld_t            ld,
    input  wire npcm_pkg::color_t              palette [PALETTE_SIZE],
    input  wire npcm_pkg::color_t              pixel_s3,
    input  wire logic [PALETTE_SIZE-1:0]       hit_s3,
    input  wire npcm_pkg::dist_t               dist_s3 [PALETTE_SIZE],
    output npcm_pkg::color_t                   out_color,
    output logic                               matched,
    output logic [npcm_pkg::IDX_W-1:0]         palette_index
);
    import npcm_pkg::*;

    localparam int HALF    = MAX_ENTRIES / 2;
    localparam int QUARTER = MAX_ENTRIES / 4;

    cand_t   leaf      [MAX_ENTRIES];
    color_t  pal_full  [MAX_ENTRIES];
    cand_t   pair4_reg [HALF];
    color_t  pix4_reg;
    cand_t   quad      [QUARTER];
    cand_t   best;
    color_t  color5_reg;
    logic    hit5_reg;
    logic [IDX_W-1:0] idx5_reg;

    // pad unused lanes with entries that never match
    generate
        for (genvar e = 0; e < MAX_ENTRIES; e++)
        begin : g_leaf
            if (e < PALETTE_SIZE)
            begin : g_used
                assign leaf[e]     = '{hit: hit_s3[e], sq_sum: dist_s3[e], idx: IDX_W'(e)};
                assign pal_full[e] = palette[e];
            end
            else
            begin : g_pad
                assign leaf[e]     = '{hit: 1'b0, sq_sum: '0, idx: IDX_W'(e)};
                assign pal_full[e] = '0;
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (ld.ld_s4)
        begin
            pix4_reg <= pixel_s3;
            for (int j = 0; j < HALF; j++)
            begin
                pair4_reg[j] <= pick_closer(leaf[2*j], leaf[2*j+1]);
            end
        end
    end

    always_comb
    begin
        for (int j = 0; j < QUARTER; j++)
        begin
            quad[j] = pick_closer(pair4_reg[2*j], pair4_reg[2*j+1]);
        end
        best = pick_closer(quad[0], quad[1]);
    end

    always_ff @(posedge clk)
    begin
        if (ld.ld_s5)
        begin
            hit5_reg   <= best.hit;
            idx5_reg   <= best.hit ? best.idx : '0;
            color5_reg <= best.hit ? pal_full[best.idx] : pix4_reg;
        end
    end

    assign out_color     = color5_reg;
    assign matched       = hit5_reg;
    assign palette_index = idx5_reg;

endmodule
`default_nettype wire

### hdl/nearest_palette_color_mapper_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_palette_color_mapper_unit
// Maps RGB888 pixels to the nearest of up to eight palette colors.
// ----------------------------------------------------------------------------
// Takes one pixel per clock and passes it through five registered stages:
// three stages form the squared RGB distance to every palette entry in
// parallel lanes (difference, square, sum with bound check), two stages
// reduce them in a compare tree and register the output. Throughput is
// one pixel per clock; bubbles collapse, so the block keeps taking pixels
// until all five stages hold data and the output is stalled. The closest
// entry strictly below max_distance wins, the lower index on ties; with no
// match the pixel passes through with matched low and index zero. Write the
// configuration registers only while no pixel is in flight.
// ----------------------------------------------------------------------------
module nearest_palette_color_mapper_unit #(
    parameter int PALETTE_SIZE = npcm_pkg::MAX_ENTRIES
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [npcm_pkg::COLOR_W-1:0]     pixel_color,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic [npcm_pkg::COLOR_W-1:0]          out_color,
    output logic                                  matched,
    output logic [npcm_pkg::IDX_W-1:0]            palette_index,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [npcm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [npcm_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import npcm_pkg::*;

    `include "nearest_palette_color_mapper_unit_assert.svh"

    logic [STAGES-1:0] v_reg;
    logic [STAGES-1:0] v_next;
    logic [STAGES-1:0] en;
    pipe_ld_t          ld;
    cfg_ctl_t          cfg_ctl;
    color_t            palette [PALETTE_SIZE];
    color_t            pixel_s3;
    logic [PALETTE_SIZE-1:0] hit_s3;
    dist_t             dist_s3 [PALETTE_SIZE];

    // a stage advances when empty or when the stage after it advances
    always_comb
    begin
        en[STAGES-1] = !v_reg[STAGES-1] || !out_stall;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
        v_next = v_reg;
        if (en[0])
        begin
            v_next[0] = in_valid;
        end
        for (int k = 1; k < STAGES; k++)
        begin
            if (en[k])
            begin
                v_next[k] = v_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign ld.ld_s1 = en[0];
    assign ld.ld_s2 = en[1];
    assign ld.ld_s3 = en[2];
    assign ld.ld_s4 = en[3];
    assign ld.ld_s5 = en[4];

    assign in_stall  = !en[0];
    assign out_valid = v_reg[STAGES-1];

    npcm_cfg #(
        .PALETTE_SIZE (PALETTE_SIZE)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_ctl   (cfg_ctl),
        .palette   (palette)
    );

    npcm_dist #(
        .PALETTE_SIZE (PALETTE_SIZE)
    ) u_dist (
        .clk      (clk),
        .ld       (ld),
        .cfg_ctl  (cfg_ctl),
        .palette  (palette),
        .pixel_in (pixel_color),
        .pixel_s3 (pixel_s3),
        .hit_s3   (hit_s3),
        .dist_s3  (dist_s3)
    );

    npcm_select #(
        .PALETTE_SIZE (PALETTE_SIZE)
    ) u_select (
        .clk           (clk),
        .ld            (ld),
        .palette       (palette),
        .pixel_s3      (pixel_s3),
        .hit_s3        (hit_s3),
        .dist_s3       (dist_s3),
        .out_color     (out_color),
        .matched       (matched),
        .palette_index (palette_index)
    );

    // back-pressure on the input only ever comes from a full, stalled pipeline
    `NPCM_ASSERT_NOW(a_stall_source, in_stall, out_valid && out_stall && (&v_reg), "input stalled while pipeline has room")
    `NPCM_ASSERT_NOW(a_index_active, out_valid && matched, NUM_W'(palette_index) < cfg_ctl.num_colors, "match on inactive entry")
    `NPCM_ASSERT_NOW(a_zero_bound, out_valid && matched, cfg_ctl.max_distance != '0, "match with zero distance bound")

endmodule
`default_nettype wire
